// ----- src/sdq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_pkg: shared types and codes of the sorted delay queue
// Item layouts of the request and response channels and the operation codes.
// ----------------------------------------------------------------------------
package sdq_pkg;

	localparam logic [3:0] MODE_INSERT     = 4'd0;
	localparam logic [3:0] MODE_REWIND     = 4'd1;
	localparam logic [3:0] MODE_STEP       = 4'd2;
	localparam logic [3:0] MODE_STEP_WRAP  = 4'd3;
	localparam logic [3:0] MODE_SEEK_ID    = 4'd4;
	localparam logic [3:0] MODE_READ_CUR   = 4'd5;
	localparam logic [3:0] MODE_HAS_ID     = 4'd6;
	localparam logic [3:0] MODE_HAS_TYPE   = 4'd7;
	localparam logic [3:0] MODE_REMOVE_CUR = 4'd8;
	localparam logic [3:0] MODE_REMOVE_ID  = 4'd9;
	localparam logic [3:0] MODE_HEAD       = 4'd10;
	localparam logic [3:0] MODE_TICK       = 4'd11;
	localparam logic [3:0] MODE_PURGE      = 4'd12;

	typedef struct packed {
		logic [3:0]         mode;
		logic [7:0]         obj_type;
		logic [31:0]        delay_ms;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [15:0]        target_id;
		logic [31:0]        elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic               ok;
		logic               list_empty;
		logic               cursor_valid;
		logic [15:0]        entry_id;
		logic [7:0]         entry_type;
		logic [31:0]        entry_delay;
		logic signed [31:0] entry_pos_x;
		logic signed [31:0] entry_pos_y;
		logic signed [31:0] entry_pos_z;
		logic signed [31:0] entry_vel_x;
		logic signed [31:0] entry_vel_y;
		logic signed [31:0] entry_vel_z;
	} out_item_t;

endpackage
`default_nettype wire

// ----- src/sdq_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_if: request and response channels of the sorted delay queue
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sdq_in_if;
	logic             valid;
	logic             ready;
	sdq_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sdq_out_if;
	logic              valid;
	logic              ready;
	sdq_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/sorted_delay_queue_with_aging_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_delay_queue_with_aging_top: sorted timer queue with aging
// Each request item on req gives exactly one response item on rsp. Records
// live in one memory in ascending delay order; a sequencer walks it with one
// read and one write port per cycle.
// Timing: an item is taken only when the sequencer is idle. Cursor moves,
// rewind, purge and operations that fail at once go straight to the done
// state, which loads the response register; read and head pass through the
// fetch and show states first. Insert reads the head, then walks down from
// the tail; removal and the id and type searches walk up through the memory.
// Each moves one record per cycle.
// A tick visits each record in turn with one shared 32x32 multiplier and a
// radix-16 divider by 1000.
// The response register frees the sequencer: a new item is taken while the
// previous response still waits, and a stalled rsp holds only the finish of
// the following item. Reset empties the queue, clears the id counter and the
// cursor; the memory contents are not cleared, the record count guards them.
// ----------------------------------------------------------------------------
module sorted_delay_queue_with_aging_top #(
	parameter int MAX_ENTRIES = 64,
	parameter int ID_BITS     = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sdq_in_if.sink     req,
	sdq_out_if.source  rsp
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [7:0]         otype;
		logic [31:0]        delay;
		logic [2:0][31:0]   pos;
		logic [2:0][31:0]   vel;
	} rec_t;

	typedef enum logic [4:0] {
		S_IDLE, S_INS_HD, S_INS, S_INS_PUT, S_RM_INIT, S_RMV, S_RM_FIN, S_SCAN,
		S_FETCH, S_SHOW, S_TK_RD, S_TK_LD, S_TK_MUL, S_TK_PRE, S_TK_DIV,
		S_TK_ADD, S_TK_WR, S_DONE
	} state_t;

	state_t             state_q;
	sdq_pkg::in_item_t  cmd_q;
	sdq_pkg::out_item_t res_q;
	sdq_pkg::out_item_t out_q;
	logic               ov_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      cur_q;
	logic               cur_on_q;
	logic [ID_BITS-1:0] id_q;
	logic [IW-1:0]      ia_q;
	logic               live_q;
	logic               rv_s1;
	logic [IW-1:0]      ridx_s1;
	logic               first_q;
	logic               head_le_q;
	logic [IW-1:0]      pos_q;
	logic [IW-1:0]      rm_q;
	logic [IW-1:0]      tk_q;
	logic [1:0]         f_q;
	rec_t               w_q;
	logic               neg_q;
	logic [63:0]        prod_q;
	logic [63:0]        n_q;
	logic [9:0]         rem_q;
	logic [63:0]        qt_q;
	logic [3:0]         dg_q;

	rec_t               mem_q [MAX_ENTRIES];
	rec_t               rd_q;

	logic [IW-1:0]      ra;
	logic               we;
	logic [IW-1:0]      wa;
	rec_t               wd;
	logic               issue;

	logic [IW-1:0]      last_i;
	logic               shift_c;
	logic               match_c;
	logic [ID_BITS-1:0] nid_raw;
	logic [ID_BITS-1:0] nid;
	logic [31:0]        nid32;
	logic [31:0]        rid32;
	rec_t               new_rec;
	logic [13:0]        dv_t;
	logic [3:0]         dv_qd;
	logic [9:0]         dv_rem;
	logic [31:0]        vsel;
	logic [31:0]        vabs;
	logic [31:0]        psel;
	logic [34:0]        p_ext;
	logic [34:0]        q_ext;
	logic [34:0]        p_sum;
	logic [31:0]        p_new;
	logic [31:0]        d_new;
	logic [CW-1:0]      cur_ext;
	logic               load_out;
	sdq_pkg::out_item_t done_item;

	assign last_i  = IW'(count_q - CW'(1));
	assign cur_ext = CW'(cur_q);
	// A delay not above the head goes first, even when it equals the tail.
	assign shift_c = first_q ? (head_le_q || (rd_q.delay > cmd_q.delay_ms))
	                         : (rd_q.delay >= cmd_q.delay_ms);
	assign rid32   = 32'(rd_q.id);
	assign match_c = (cmd_q.mode == sdq_pkg::MODE_HAS_TYPE)
	                 ? (rd_q.otype == cmd_q.obj_type)
	                 : (rid32 == 32'(cmd_q.target_id));
	assign nid_raw = id_q + ID_BITS'(1);
	assign nid     = (nid_raw == '0) ? ID_BITS'(1) : nid_raw;
	assign nid32   = 32'(nid);
	assign load_out = (state_q == S_DONE) && (!ov_q || rsp.ready);

	always_comb begin
		done_item              = res_q;
		done_item.list_empty   = (count_q == '0);
		done_item.cursor_valid = cur_on_q;
	end

	always_comb begin
		new_rec.id     = nid;
		new_rec.otype  = cmd_q.obj_type;
		new_rec.delay  = cmd_q.delay_ms;
		new_rec.pos[0] = cmd_q.pos_x;
		new_rec.pos[1] = cmd_q.pos_y;
		new_rec.pos[2] = cmd_q.pos_z;
		new_rec.vel[0] = cmd_q.vel_x;
		new_rec.vel[1] = cmd_q.vel_y;
		new_rec.vel[2] = cmd_q.vel_z;
	end

	// One radix-16 digit of the division by 1000.
	always_comb begin
		dv_t  = {rem_q, n_q[63:60]};
		dv_qd = '0;
		for (int k = 1; k < 16; k++) begin
			if (dv_t >= 14'(k * 1000)) dv_qd = 4'(k);
		end
		dv_rem = 10'(dv_t - 14'(dv_qd) * 14'd1000);
	end

	// Position update for the current axis, saturated to signed 32 bits.
	always_comb begin
		vsel  = w_q.vel[f_q];
		vabs  = vsel[31] ? (~vsel + 32'd1) : vsel;
		psel  = w_q.pos[f_q];
		p_ext = {{3{psel[31]}}, psel};
		q_ext = {2'b00, qt_q[32:0]};
		p_sum = neg_q ? (p_ext - q_ext) : (p_ext + q_ext);
		if (|qt_q[63:33]) begin
			p_new = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if ((p_sum[34:31] == 4'b0000) || (p_sum[34:31] == 4'b1111)) begin
			p_new = p_sum[31:0];
		end else begin
			p_new = p_sum[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		d_new = (rd_q.delay < cmd_q.elapsed_ms) ? 32'd0 : (rd_q.delay - cmd_q.elapsed_ms);
	end

	always_comb begin
		ra    = ia_q;
		we    = 1'b0;
		wa    = ridx_s1;
		wd    = rd_q;
		issue = 1'b0;
		case (state_q)
			// The head is read while idle so that an insert can test it at once.
			S_IDLE: ra = '0;
			S_INS: begin
				issue = live_q;
				if (rv_s1 && shift_c) begin
					we = 1'b1;
					wa = IW'(ridx_s1 + 1'b1);
				end
			end
			S_INS_PUT: begin
				we = 1'b1;
				wa = pos_q;
				wd = new_rec;
			end
			S_RMV: begin
				issue = live_q;
				if (rv_s1) begin
					we = 1'b1;
					wa = IW'(ridx_s1 - 1'b1);
				end
			end
			S_SCAN:  issue = live_q;
			S_TK_RD: ra = tk_q;
			S_TK_WR: begin
				we = 1'b1;
				wa = tk_q;
				wd = w_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd_q <= mem_q[ra];
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ov_q     <= 1'b0;
			res_q    <= '0;
			count_q  <= '0;
			cur_q    <= '0;
			cur_on_q <= 1'b0;
			id_q     <= '0;
			live_q   <= 1'b0;
			rv_s1    <= 1'b0;
			first_q  <= 1'b0;
		end else begin
			rv_s1   <= issue;
			ridx_s1 <= ia_q;
			if (load_out) ov_q <= 1'b1;
			else if (rsp.valid && rsp.ready) ov_q <= 1'b0;

			if (issue) begin
				if (state_q == S_INS) begin
					if (ia_q == '0) live_q <= 1'b0;
					else ia_q <= IW'(ia_q - 1'b1);
				end else begin
					if (ia_q == last_i) live_q <= 1'b0;
					else ia_q <= IW'(ia_q + 1'b1);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q <= req.data;
						state_q <= S_DONE;
						case (req.data.mode)
							sdq_pkg::MODE_INSERT: begin
								if (count_q < CW'(MAX_ENTRIES)) begin
									if (count_q == '0) begin
										pos_q   <= '0;
										state_q <= S_INS_PUT;
									end else begin
										state_q <= S_INS_HD;
									end
								end
							end
							sdq_pkg::MODE_REWIND: begin
								cur_q     <= '0;
								cur_on_q  <= (count_q != '0);
								res_q.ok  <= 1'b1;
							end
							sdq_pkg::MODE_STEP: begin
								if (cur_on_q) begin
									if (cur_ext + CW'(1) < count_q) begin
										cur_q <= IW'(cur_q + 1'b1);
									end else begin
										cur_on_q <= 1'b0;
										cur_q    <= '0;
									end
									res_q.ok <= 1'b1;
								end
							end
							sdq_pkg::MODE_STEP_WRAP: begin
								if (count_q != '0) begin
									cur_on_q <= 1'b1;
									if (!cur_on_q) begin
										cur_q <= (count_q > CW'(1)) ? IW'(1) : '0;
									end else if (cur_ext + CW'(1) < count_q) begin
										cur_q <= IW'(cur_q + 1'b1);
									end else begin
										cur_q <= '0;
									end
									res_q.ok <= 1'b1;
								end
							end
							sdq_pkg::MODE_SEEK_ID, sdq_pkg::MODE_HAS_ID,
							sdq_pkg::MODE_HAS_TYPE, sdq_pkg::MODE_REMOVE_ID: begin
								if (count_q != '0) begin
									ia_q    <= '0;
									live_q  <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							sdq_pkg::MODE_READ_CUR: begin
								if (cur_on_q && (cur_ext < count_q)) begin
									ia_q    <= cur_q;
									state_q <= S_FETCH;
								end
							end
							sdq_pkg::MODE_REMOVE_CUR: begin
								if (cur_on_q && (cur_ext < count_q)) begin
									rm_q    <= cur_q;
									state_q <= S_RM_INIT;
								end
							end
							sdq_pkg::MODE_HEAD: begin
								if (count_q != '0) begin
									ia_q    <= '0;
									state_q <= S_FETCH;
								end
							end
							sdq_pkg::MODE_TICK: begin
								res_q.ok <= 1'b1;
								if (count_q != '0) begin
									tk_q    <= '0;
									state_q <= S_TK_RD;
								end
							end
							sdq_pkg::MODE_PURGE: begin
								count_q  <= '0;
								cur_on_q <= 1'b0;
								cur_q    <= '0;
								id_q     <= '0;
								res_q.ok <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_INS_HD: begin
					head_le_q <= (cmd_q.delay_ms <= rd_q.delay);
					ia_q      <= last_i;
					live_q    <= 1'b1;
					first_q   <= 1'b1;
					state_q   <= S_INS;
				end
				// Walk down from the tail, moving larger records, and equal ones below the tail, up by one.
				S_INS: begin
					if (rv_s1) begin
						first_q <= 1'b0;
						if (!shift_c) begin
							pos_q   <= IW'(ridx_s1 + 1'b1);
							state_q <= S_INS_PUT;
						end else if (ridx_s1 == '0) begin
							pos_q   <= '0;
							state_q <= S_INS_PUT;
						end
					end
				end
				S_INS_PUT: begin
					id_q    <= nid;
					count_q <= CW'(count_q + 1'b1);
					if (cur_on_q && (pos_q <= cur_q)) cur_q <= IW'(cur_q + 1'b1);
					res_q.ok       <= 1'b1;
					res_q.entry_id <= nid32[15:0];
					state_q        <= S_DONE;
				end
				S_RM_INIT: begin
					if (rm_q == last_i) begin
						state_q <= S_RM_FIN;
					end else begin
						ia_q    <= IW'(rm_q + 1'b1);
						live_q  <= 1'b1;
						state_q <= S_RMV;
					end
				end
				S_RMV: begin
					if (rv_s1 && (ridx_s1 == last_i)) state_q <= S_RM_FIN;
				end
				S_RM_FIN: begin
					count_q  <= CW'(count_q - 1'b1);
					cur_on_q <= 1'b0;
					cur_q    <= '0;
					res_q.ok <= 1'b1;
					state_q  <= S_DONE;
				end
				S_SCAN: begin
					if (rv_s1) begin
						if (match_c) begin
							case (cmd_q.mode)
								sdq_pkg::MODE_SEEK_ID: begin
									cur_on_q <= 1'b1;
									cur_q    <= ridx_s1;
									res_q.ok <= 1'b1;
									state_q  <= S_DONE;
								end
								sdq_pkg::MODE_REMOVE_ID: begin
									rm_q    <= ridx_s1;
									state_q <= S_RM_INIT;
								end
								default: begin
									res_q.ok <= 1'b1;
									state_q  <= S_DONE;
								end
							endcase
						end else if (ridx_s1 == last_i) begin
							state_q <= S_DONE;
						end
					end
				end
				S_FETCH: state_q <= S_SHOW;
				S_SHOW: begin
					res_q.ok          <= 1'b1;
					res_q.entry_id    <= rid32[15:0];
					res_q.entry_type  <= rd_q.otype;
					res_q.entry_delay <= rd_q.delay;
					res_q.entry_pos_x <= rd_q.pos[0];
					res_q.entry_pos_y <= rd_q.pos[1];
					res_q.entry_pos_z <= rd_q.pos[2];
					res_q.entry_vel_x <= rd_q.vel[0];
					res_q.entry_vel_y <= rd_q.vel[1];
					res_q.entry_vel_z <= rd_q.vel[2];
					state_q           <= S_DONE;
				end
				S_TK_RD: state_q <= S_TK_LD;
				S_TK_LD: begin
					w_q     <= '{id: rd_q.id, otype: rd_q.otype, delay: d_new,
					             pos: rd_q.pos, vel: rd_q.vel};
					f_q     <= '0;
					state_q <= S_TK_MUL;
				end
				S_TK_MUL: begin
					neg_q   <= vsel[31];
					prod_q  <= 64'(vabs) * 64'(cmd_q.elapsed_ms);
					state_q <= S_TK_PRE;
				end
				S_TK_PRE: begin
					// Adding half the divisor rounds ties away from zero.
					n_q     <= prod_q + 64'd500;
					rem_q   <= '0;
					qt_q    <= '0;
					dg_q    <= '0;
					state_q <= S_TK_DIV;
				end
				S_TK_DIV: begin
					n_q   <= {n_q[59:0], 4'b0000};
					rem_q <= dv_rem;
					qt_q  <= {qt_q[59:0], dv_qd};
					dg_q  <= dg_q + 4'd1;
					if (dg_q == 4'd15) state_q <= S_TK_ADD;
				end
				S_TK_ADD: begin
					w_q.pos[f_q] <= p_new;
					if (f_q == 2'd2) begin
						state_q <= S_TK_WR;
					end else begin
						f_q     <= f_q + 2'd1;
						state_q <= S_TK_MUL;
					end
				end
				S_TK_WR: begin
					if (tk_q == last_i) begin
						state_q <= S_DONE;
					end else begin
						tk_q    <= IW'(tk_q + 1'b1);
						state_q <= S_TK_RD;
					end
				end
				S_DONE: begin
					if (load_out) begin
						out_q   <= done_item;
						res_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/sdq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_checker: port-level checks of the sorted delay queue
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module sdq_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire sdq_pkg::out_item_t out_data
);

	// A response waiting for the receiver keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response changed while stalled");

	// The sequencer is not ready again in the cycle after taking an item.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken on consecutive cycles");

	// A valid cursor implies a nonempty queue.
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.list_empty && out_data.cursor_valid))
		else $error("cursor valid on an empty queue");

	// A failed operation reports no record.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> (out_data.entry_id == 16'd0) &&
			(out_data.entry_delay == 32'd0) && (out_data.entry_type == 8'd0))
		else $error("failed operation returned record data");

endmodule

bind sorted_delay_queue_with_aging_top sdq_checker u_sdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_data  (rsp.data)
);
`default_nettype wire
